// ===== design/tilt_complementary_filter_core_macros.svh =====
// Assertion macros for the tilt complementary filter core.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcf_pkg.sv =====
// Shared types, widths, register codes and the CORDIC arctangent table
// for the tilt complementary filter. No dependencies.
`default_nettype none

package tcf_pkg;

    localparam int ANG_W      = 27;  // CORDIC operands and angles, 2^-16 degree
    localparam int MUL_W      = 26;  // shared multiplier operand width
    localparam int ACC_W      = 60;  // multiply-accumulate register width
    localparam int DIFF_W     = 43;  // gyro path minus accel path, 2^-28 degree
    localparam int EST_W      = 20;  // estimates, 1/256 degree
    localparam int RND_W      = 24;  // rounded blend before saturation
    localparam int ATAN_DEPTH = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd1;

    localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd32768;
    localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;

    localparam logic signed [ANG_W-1:0] HALF_TURN  = 27'sd11796480;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 60'sd34359738368;  // 2^35
    localparam logic signed [EST_W-1:0] EST_MAX    = 20'sd524287;
    localparam logic signed [EST_W-1:0] EST_MIN    = -20'sd524288;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_ROLL_GO,
        S_ROLL_WAIT,
        S_PITCH_GO,
        S_PITCH_WAIT,
        S_BL_RATE,
        S_BL_DIFF,
        S_BL_LO,
        S_BL_HI,
        S_BL_ROUND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic en;    // update the accumulator
        logic add;   // add to it instead of loading
        logic sh21;  // product weighted by 2^21
    } t_mac_cmd;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [21:0] atan_step(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/tcf_if.sv =====
// Valid/ready channel interfaces for IMU samples and filter results.
// No dependencies.
`default_nettype none

interface tcf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z,
                    input ready);
    modport sink (input valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z,
                  output ready);
endinterface

interface tcf_result_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] roll_angle;
    logic signed [19:0] pitch_angle;
    logic signed [15:0] yaw_rate;

    modport source (output valid, roll_angle, pitch_angle, yaw_rate, input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_rate, output ready);
endinterface

`default_nettype wire

// ===== design/tilt_complementary_filter_core.sv =====
// Tilt complementary filter top level: sequencer, blend datapath, registers.
// Depends on tcf_pkg, tcf_if, tcf_mac, tcf_isqrt, tcf_cordic and the macro header.
//
// Usage:
//   i_sample takes one IMU sample (three gyro rates, three accelerometer axes)
//   per valid/ready transfer; o_result gives one transfer per sample with the
//   filtered roll and pitch (1/256 degree, saturated) and gyro_z unchanged.
//   i_cfg_we/i_cfg_idx/i_cfg_data write blend_weight (index 0) and
//   sample_period (index 1); write only while no sample is in flight.
//   The time between samples is set by the 24-step square root, run alongside
//   the roll arctangent, the pitch arctangent on the same CORDIC, and the
//   shared multiplier for the two blends. i_sample.ready is high only while
//   the sequencer is idle.
//   The result sits in an output register; a stalled receiver does not block
//   the next sample, which waits at the end only if the register is still full.
//   Reset clears both estimates, restores the register defaults and empties
//   the output register.
`default_nettype none
`include "tilt_complementary_filter_core_macros.svh"

module tilt_complementary_filter_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    tcf_sample_if.sink                              i_sample,
    tcf_result_if.source                            o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tcf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    tcf_pkg::t_state r_state;
    tcf_pkg::t_state n_state;

    logic [15:0] r_blend_weight;
    logic [23:0] r_sample_period;

    logic signed [15:0] r_gx;
    logic signed [15:0] r_gy;
    logic signed [15:0] r_gz;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;

    logic                                r_axis;
    logic signed [tcf_pkg::ANG_W-1:0]    r_roll_acc;
    logic signed [tcf_pkg::DIFF_W-1:0]   r_diff;
    logic signed [tcf_pkg::EST_W-1:0]    r_roll_est;
    logic signed [tcf_pkg::EST_W-1:0]    r_pitch_est;

    logic                                r_out_valid;
    logic signed [tcf_pkg::EST_W-1:0]    r_out_roll;
    logic signed [tcf_pkg::EST_W-1:0]    r_out_pitch;
    logic signed [15:0]                  r_out_yaw;

    tcf_pkg::t_mac_cmd                   mac_cmd;
    logic signed [tcf_pkg::MUL_W-1:0]    mac_a;
    logic signed [tcf_pkg::MUL_W-1:0]    mac_b;
    logic signed [tcf_pkg::ACC_W-1:0]    mac_acc;

    logic                                cordic_start;
    logic signed [tcf_pkg::ANG_W-1:0]    cordic_x;
    logic signed [tcf_pkg::ANG_W-1:0]    cordic_y;
    logic                                cordic_busy;
    logic signed [tcf_pkg::ANG_W-1:0]    cordic_angle;

    logic                                sqrt_start;
    logic                                sqrt_busy;
    logic [23:0]                         sqrt_root;

    logic                                sample_ready;
    logic                                in_xfer;
    logic                                out_load;
    logic                                units_idle;

    logic signed [15:0]                  rate_sel;
    logic signed [tcf_pkg::ANG_W-1:0]    ang_sel;
    logic signed [tcf_pkg::EST_W-1:0]    old_sel;
    logic signed [tcf_pkg::DIFF_W-1:0]   diff_next;
    logic signed [tcf_pkg::ACC_W-1:0]    rnd_sum;
    logic signed [tcf_pkg::RND_W-1:0]    rnd_q;
    logic signed [tcf_pkg::EST_W-1:0]    est_new;

    tcf_mac u_mac (
        .i_clk   (i_clk),
        .i_cmd   (mac_cmd),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    tcf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (mac_acc[31:0]),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    tcf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (cordic_x),
        .i_y     (cordic_y),
        .o_busy  (cordic_busy),
        .o_angle (cordic_angle)
    );

    assign in_xfer    = i_sample.valid && sample_ready;
    assign units_idle = !cordic_busy && !sqrt_busy;

    // blend datapath
    always_comb begin
        rate_sel  = r_axis ? r_gy : r_gx;
        ang_sel   = r_axis ? cordic_angle : r_roll_acc;
        old_sel   = r_axis ? r_pitch_est : r_roll_est;
        diff_next = (tcf_pkg::DIFF_W'(old_sel) <<< 20)
                  + signed'(mac_acc[tcf_pkg::DIFF_W-1:0])
                  - (tcf_pkg::DIFF_W'(ang_sel) <<< 12);
        rnd_sum   = mac_acc + (tcf_pkg::ACC_W'(ang_sel) <<< 28) + tcf_pkg::ROUND_BIAS;
        rnd_q     = signed'(rnd_sum[tcf_pkg::ACC_W-1 -: tcf_pkg::RND_W]);
        if (rnd_q > tcf_pkg::RND_W'(tcf_pkg::EST_MAX)) begin
            est_new = tcf_pkg::EST_MAX;
        end else if (rnd_q < tcf_pkg::RND_W'(tcf_pkg::EST_MIN)) begin
            est_new = tcf_pkg::EST_MIN;
        end else begin
            est_new = rnd_q[tcf_pkg::EST_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcf_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = tcf_pkg::S_SQ0;
                end
            end
            tcf_pkg::S_SQ0:      n_state = tcf_pkg::S_SQ1;
            tcf_pkg::S_SQ1:      n_state = tcf_pkg::S_ROLL_GO;
            tcf_pkg::S_ROLL_GO:  n_state = tcf_pkg::S_ROLL_WAIT;
            tcf_pkg::S_ROLL_WAIT: begin
                if (units_idle) begin
                    n_state = tcf_pkg::S_PITCH_GO;
                end
            end
            tcf_pkg::S_PITCH_GO: n_state = tcf_pkg::S_PITCH_WAIT;
            tcf_pkg::S_PITCH_WAIT: begin
                if (!cordic_busy) begin
                    n_state = tcf_pkg::S_BL_RATE;
                end
            end
            tcf_pkg::S_BL_RATE:  n_state = tcf_pkg::S_BL_DIFF;
            tcf_pkg::S_BL_DIFF:  n_state = tcf_pkg::S_BL_LO;
            tcf_pkg::S_BL_LO:    n_state = tcf_pkg::S_BL_HI;
            tcf_pkg::S_BL_HI:    n_state = tcf_pkg::S_BL_ROUND;
            tcf_pkg::S_BL_ROUND: n_state = r_axis ? tcf_pkg::S_OUT : tcf_pkg::S_BL_RATE;
            tcf_pkg::S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = tcf_pkg::S_IDLE;
                end
            end
            default:             n_state = tcf_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        sample_ready = 1'b0;
        mac_cmd      = '0;
        mac_a        = '0;
        mac_b        = '0;
        cordic_start = 1'b0;
        cordic_x     = '0;
        cordic_y     = '0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            tcf_pkg::S_IDLE: begin
                sample_ready = 1'b1;
            end
            tcf_pkg::S_SQ0: begin
                mac_cmd = '{en: 1'b1, add: 1'b0, sh21: 1'b0};
                mac_a   = tcf_pkg::MUL_W'(r_ay);
                mac_b   = tcf_pkg::MUL_W'(r_ay);
            end
            tcf_pkg::S_SQ1: begin
                mac_cmd = '{en: 1'b1, add: 1'b1, sh21: 1'b0};
                mac_a   = tcf_pkg::MUL_W'(r_az);
                mac_b   = tcf_pkg::MUL_W'(r_az);
            end
            tcf_pkg::S_ROLL_GO: begin
                sqrt_start   = 1'b1;
                cordic_start = 1'b1;
                cordic_x     = tcf_pkg::ANG_W'(r_az) <<< 8;
                cordic_y     = tcf_pkg::ANG_W'(r_ay) <<< 8;
            end
            tcf_pkg::S_PITCH_GO: begin
                cordic_start = 1'b1;
                cordic_x     = signed'(tcf_pkg::ANG_W'(sqrt_root));
                cordic_y     = -(tcf_pkg::ANG_W'(r_ax) <<< 8);
            end
            tcf_pkg::S_BL_RATE: begin
                mac_cmd = '{en: 1'b1, add: 1'b0, sh21: 1'b0};
                mac_a   = tcf_pkg::MUL_W'(rate_sel);
                mac_b   = signed'(tcf_pkg::MUL_W'(r_sample_period));
            end
            tcf_pkg::S_BL_LO: begin
                mac_cmd = '{en: 1'b1, add: 1'b0, sh21: 1'b0};
                mac_a   = signed'(tcf_pkg::MUL_W'(r_blend_weight));
                mac_b   = signed'(tcf_pkg::MUL_W'(r_diff[20:0]));
            end
            tcf_pkg::S_BL_HI: begin
                mac_cmd = '{en: 1'b1, add: 1'b1, sh21: 1'b1};
                mac_a   = signed'(tcf_pkg::MUL_W'(r_blend_weight));
                mac_b   = tcf_pkg::MUL_W'(signed'(r_diff[tcf_pkg::DIFF_W-1:21]));
            end
            tcf_pkg::S_OUT: begin
                out_load = !r_out_valid || o_result.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight  <= tcf_pkg::BLEND_WEIGHT_RST;
            r_sample_period <= tcf_pkg::SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcf_pkg::REG_BLEND_WEIGHT:  r_blend_weight  <= i_cfg_data[15:0];
                tcf_pkg::REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_gx <= i_sample.gyro_x;
            r_gy <= i_sample.gyro_y;
            r_gz <= i_sample.gyro_z;
            r_ax <= i_sample.acc_x;
            r_ay <= i_sample.acc_y;
            r_az <= i_sample.acc_z;
        end
        if (r_state == tcf_pkg::S_ROLL_WAIT && units_idle) begin
            r_roll_acc <= cordic_angle;
        end
        if (r_state == tcf_pkg::S_BL_DIFF) begin
            r_diff <= diff_next;
        end
        if (out_load) begin
            r_out_roll  <= r_roll_est;
            r_out_pitch <= r_pitch_est;
            r_out_yaw   <= r_gz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= 1'b0;
            r_roll_est  <= '0;
            r_pitch_est <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_axis <= 1'b0;
            end else if (r_state == tcf_pkg::S_BL_ROUND) begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_pitch_est <= est_new;
                end else begin
                    r_roll_est <= est_new;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_sample.ready       = sample_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.roll_angle  = r_out_roll;
    assign o_result.pitch_angle = r_out_pitch;
    assign o_result.yaw_rate    = r_out_yaw;

    `TCF_ASSERT_IMP(a_units_idle, r_state == tcf_pkg::S_IDLE, units_idle, "unit busy while idle")
    `TCF_ASSERT_NXT(a_est_hold, r_state != tcf_pkg::S_BL_ROUND,
                    $stable(r_roll_est) && $stable(r_pitch_est), "estimate changed outside round step")
    `TCF_ASSERT_NXT(a_out_src, r_state != tcf_pkg::S_OUT && !r_out_valid,
                    !r_out_valid, "result shown without sequencer")
    `TCF_ASSERT_NXT(a_take, in_xfer,
                    r_state == tcf_pkg::S_SQ0 && !r_axis, "sample transfer did not start sequence")

endmodule

`default_nettype wire

// ===== design/tcf_mac.sv =====
// Shared signed multiply-accumulate unit: squares, rate times period, blend.
// Depends on tcf_pkg.
`default_nettype none

module tcf_mac (
    input  wire logic                               i_clk,
    input  wire tcf_pkg::t_mac_cmd                  i_cmd,
    input  wire logic signed [tcf_pkg::MUL_W-1:0]   i_a,
    input  wire logic signed [tcf_pkg::MUL_W-1:0]   i_b,
    output logic signed [tcf_pkg::ACC_W-1:0]        o_acc
);

    logic signed [2*tcf_pkg::MUL_W-1:0] prod;
    logic signed [tcf_pkg::ACC_W-1:0]   prod_ext;
    logic signed [tcf_pkg::ACC_W-1:0]   r_acc;

    always_comb begin
        prod     = i_a * i_b;
        prod_ext = tcf_pkg::ACC_W'(prod);
        if (i_cmd.sh21) begin
            prod_ext = prod_ext <<< 21;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= i_cmd.add ? r_acc + prod_ext : prod_ext;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== design/tcf_isqrt.sv =====
// Digit-by-digit floor square root of a 32-bit value scaled by 2^16,
// one result bit per cycle. Depends on nothing outside this file.
`default_nettype none

module tcf_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_val,
    output logic             o_busy,
    output logic [23:0]      o_root
);

    localparam int RAD_W = 48;
    localparam int REM_W = 28;
    localparam logic [4:0] LAST = 5'd23;

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [23:0]      r_root;
    logic [4:0]       r_cnt;
    logic             r_busy;

    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fits;

    always_comb begin
        cur   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        fits  = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rad  <= {i_val, 16'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? cur - trial : cur;
            r_root <= {r_root[22:0], fits};
            r_cnt  <= r_cnt + 5'd1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== design/tcf_cordic.sv =====
// Vectoring CORDIC arctangent in 2^-16 degree, one rotation per cycle
// through shifters and adders reused for every rotation. Depends on tcf_pkg.
`default_nettype none

module tcf_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [tcf_pkg::ANG_W-1:0]   i_x,
    input  wire logic signed [tcf_pkg::ANG_W-1:0]   i_y,
    output logic                                    o_busy,
    output logic signed [tcf_pkg::ANG_W-1:0]        o_angle
);

    localparam int NUM_ITER = (CORDIC_STEPS < tcf_pkg::ATAN_DEPTH) ?
                              CORDIC_STEPS : tcf_pkg::ATAN_DEPTH;
    localparam int CNT_W    = (NUM_ITER > 1) ? $clog2(NUM_ITER) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_ITER - 1);

    logic signed [tcf_pkg::ANG_W-1:0] r_x;
    logic signed [tcf_pkg::ANG_W-1:0] r_y;
    logic signed [tcf_pkg::ANG_W-1:0] r_z;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_busy;

    logic signed [tcf_pkg::ANG_W-1:0] xs;
    logic signed [tcf_pkg::ANG_W-1:0] ys;
    logic signed [tcf_pkg::ANG_W-1:0] atan_v;

    always_comb begin
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        atan_v = signed'(tcf_pkg::ANG_W'(tcf_pkg::atan_step(5'(r_cnt))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_z    <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
            if (i_x == 0 && i_y == 0) begin
                r_busy <= 1'b0;
                r_z    <= '0;
            end else if (i_x < 0) begin
                r_busy <= 1'b1;
                r_x    <= -i_x;
                r_y    <= -i_y;
                r_z    <= (i_y >= 0) ? tcf_pkg::HALF_TURN : -tcf_pkg::HALF_TURN;
            end else begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for tilt_complementary_filter_core: IMU samples in, roll/pitch out.
// Predicts each result in a scoreboard class and checks every result transfer.
// Depends on tcf_pkg, tcf_if and the core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS          = 16;
    localparam int     PHASES         = 8;
    localparam int     PHASE_ITEMS    = 204;
    localparam int     HOLD_AFTER     = 400;
    localparam int     HOLD_CYCLES    = 700;
    localparam int     TAIL_CYCLES    = 70;
    localparam longint HALF_CIRCLE    = 64'sd11796480;
    localparam longint ROUND_HALF     = 64'sd34359738368;
    localparam longint ANGLE_HI       = 64'sd524287;
    localparam longint ANGLE_LO       = -64'sd524288;
    localparam longint CORDIC_ATAN [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int PHASE_WEIGHT [PHASES] = '{0, 65535, 65535, 62259, 1, 0, 32768, 0};
    localparam int PHASE_PERIOD [PHASES] = '{1, 16777215, 0, 16777, 16777215, 0, 16777, 0};

    typedef struct {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
    } t_imu_sample;

    typedef struct {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
        logic signed [15:0] yaw;
    } t_attitude;

    class attitude_checker;
        longint    weight;
        longint    period;
        longint    roll_est;
        longint    pitch_est;
        t_attitude pending[$];
        int        errors;

        function new();
            weight    = 32768;
            period    = 16777;
            roll_est  = 0;
            pitch_est = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [tcf_pkg::CFG_IDX_W-1:0] idx,
                                logic [tcf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tcf_pkg::REG_BLEND_WEIGHT:  weight = data[15:0];
                tcf_pkg::REG_SAMPLE_PERIOD: period = data;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    -= root + bitv;
                    root  = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // vectoring CORDIC, angle in 2^-16 degree
        function longint vector_angle(longint y, longint x);
            longint z;
            longint nx;
            longint ny;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? HALF_CIRCLE : -HALF_CIRCLE;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += CORDIC_ATAN[i];
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= CORDIC_ATAN[i];
                end
                x = nx;
                y = ny;
            end
            return z;
        endfunction

        function longint blend_axis(longint old, longint rate, longint angle);
            longint gyro_path;
            longint acc_path;
            longint sum;
            longint r;
            gyro_path = old * 64'sd1048576 + rate * period;
            acc_path  = angle * 64'sd4096;
            sum       = weight * gyro_path + (64'sd65536 - weight) * acc_path;
            r         = (sum + ROUND_HALF) >>> 36;
            if (r > ANGLE_HI) r = ANGLE_HI;
            if (r < ANGLE_LO) r = ANGLE_LO;
            return r;
        endfunction

        function void take_sample(t_imu_sample s);
            longint    ay;
            longint    az;
            longint    ax;
            longint    mag;
            t_attitude a;
            ax  = s.acc_x;
            ay  = s.acc_y;
            az  = s.acc_z;
            mag = root_floor((ay * ay + az * az) << 16);
            roll_est  = blend_axis(roll_est, s.gyro_x, vector_angle(ay * 256, az * 256));
            pitch_est = blend_axis(pitch_est, s.gyro_y, vector_angle(-ax * 256, mag));
            a.roll  = roll_est[19:0];
            a.pitch = pitch_est[19:0];
            a.yaw   = s.gyro_z;
            pending.push_back(a);
        endfunction

        function void check_attitude(t_attitude got);
            t_attitude want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result roll %0d pitch %0d yaw %0d",
                         $time, got.roll, got.pitch, got.yaw);
                return;
            end
            want = pending.pop_front();
            if (got.roll !== want.roll || got.pitch !== want.pitch
                    || got.yaw !== want.yaw) begin
                errors++;
                $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d, %s %0d %s %0d %s %0d",
                         $time, want.roll, want.pitch, want.yaw,
                         "got roll", got.roll, "pitch", got.pitch, "yaw", got.yaw);
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [tcf_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             sent = 0;
    int                             seen = 0;

    attitude_checker tracker = new();

    tcf_sample_if smp();
    tcf_result_if res();

    tilt_complementary_filter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_sample(input int gx, input int gy, input int gz,
                               input int ax, input int ay, input int az);
        t_imu_sample s;
        int          gap;
        s.gyro_x = 16'(gx);
        s.gyro_y = 16'(gy);
        s.gyro_z = 16'(gz);
        s.acc_x  = 16'(ax);
        s.acc_y  = 16'(ay);
        s.acc_z  = 16'(az);
        gap = ((sent / 48) % 4 == 3) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.gyro_x <= s.gyro_x;
        smp.gyro_y <= s.gyro_y;
        smp.gyro_z <= s.gyro_z;
        smp.acc_x  <= s.acc_x;
        smp.acc_y  <= s.acc_y;
        smp.acc_z  <= s.acc_z;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        tracker.take_sample(s);
        sent++;
    endtask

    task automatic send_random();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            send_sample(spread(32768), spread(32768), spread(32768),
                        spread(32768), spread(32768), spread(32768));
        else if (kind < 8)
            send_sample(spread(800), spread(800), spread(32768),
                        spread(17000), spread(17000), spread(17000));
        else if (kind == 8)
            send_sample(corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value());
        else
            send_sample(spread(32768), spread(32768), spread(32768),
                        spread(4), spread(4), spread(4));
    endtask

    // lower valid and wait until every predicted result has been checked
    task automatic drain();
        smp.valid <= 1'b0;
        while (tracker.pending.size() > 0) @(posedge i_clk);
    endtask

    task automatic program_filter(input int weight, input int period);
        logic [tcf_pkg::CFG_DATA_W-1:0] wdata;
        wdata    = {8'($urandom), 16'(weight)};
        cfg_we   <= 1'b1;
        cfg_idx  <= tcf_pkg::REG_BLEND_WEIGHT;
        cfg_data <= wdata;
        @(posedge i_clk);
        tracker.write_reg(tcf_pkg::REG_BLEND_WEIGHT, wdata);
        cfg_idx  <= tcf_pkg::REG_SAMPLE_PERIOD;
        cfg_data <= 24'(period);
        @(posedge i_clk);
        tracker.write_reg(tcf_pkg::REG_SAMPLE_PERIOD, 24'(period));
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int weight;
        int period;
        i_rst_n    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_idx    <= tcf_pkg::REG_BLEND_WEIGHT;
        cfg_data   <= '0;
        smp.valid  <= 1'b0;
        smp.gyro_x <= '0;
        smp.gyro_y <= '0;
        smp.gyro_z <= '0;
        smp.acc_x  <= '0;
        smp.acc_y  <= '0;
        smp.acc_z  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at the reset register values
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(32767, 32767, 32767, 32767, 32767, 32767);
        send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        send_sample(0, 0, 0, 0, 0, -1000);
        send_sample(0, 0, 0, 0, 0, -32768);
        send_sample(0, 0, 0, 0, -1, -32768);
        send_sample(0, 0, 0, -32768, 0, 0);
        send_sample(0, 0, 0, 32767, 0, 0);
        send_sample(0, 0, 0, 0, 32767, 0);
        send_sample(0, 0, 0, 0, -32768, 0);
        send_sample(32767, -32768, -1, 0, 0, 16384);
        send_sample(-32768, 32767, 32767, 100, -200, 16000);
        send_sample(0, 0, 0, 0, 0, 1);
        send_sample(1, -1, 1, 0, 1, -1);
        send_sample(-1, 1, -32768, 32767, -32768, 32767);
        send_sample(16, -16, 256, -8000, 12000, -15000);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            weight = PHASE_WEIGHT[phase];
            period = PHASE_PERIOD[phase];
            if (phase == 5 || phase == 7) begin
                weight = $urandom_range(0, 65535);
                period = $urandom_range(1, 16777215);
            end
            program_filter(weight, period);
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (tracker.pending.size() != 0)
                $display("%0t: %0d results never arrived", $time, tracker.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int        stall;
        t_attitude got;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (seen == HOLD_AFTER)
                stall = HOLD_CYCLES;
            else if ((seen / 64) % 4 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
            while (!res.valid) @(posedge i_clk);
            got.roll  = res.roll_angle;
            got.pitch = res.pitch_angle;
            got.yaw   = res.yaw_rate;
            tracker.check_attitude(got);
            seen++;
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("%0t: timeout, %0d samples sent, %0d results seen", $time, sent, seen);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
